@@ rtl/crv_pkg.sv @@
// ----------------------------------------------------------------------------
// crv_pkg - settings record validate/decode shared definitions
// Types, status codes and constants used by the front, queue and back stages.
// ----------------------------------------------------------------------------
package crv_pkg;

  localparam int NEW_SCHEMA_VERSION_DEF = 2;
  localparam int NEW_RECORD_VERSION_DEF = 2;

  localparam logic [7:0] NEW_BODY_SIZE    = 8'd18;
  localparam logic [4:0] NEW_RECORD_SIZE  = 5'd28;
  localparam logic [7:0] OLD_VERSION      = 8'd1;
  localparam logic [7:0] OLD_BODY_SIZE    = 8'd16;
  localparam logic [4:0] OLD_RECORD_SIZE  = 5'd26;
  localparam logic [31:0] CRC_POLY        = 32'hEDB88320;
  localparam logic [15:0] MHZ_MIN         = 16'd320;
  localparam logic [15:0] MHZ_MAX         = 16'd400;
  localparam logic [15:0] GAIN_MIN        = 16'h0100;
  localparam logic [15:0] GAIN_MAX        = 16'h0200;
  localparam logic [7:0] IDLE_MAX         = 8'd60;
  localparam logic [31:0] OUTER_MAGIC     = 32'h5731364D;
  localparam logic [31:0] INNER_MAGIC     = 32'h4331364D;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_LEN  = 3'd1;
  localparam logic [2:0] ST_BAD_MAG  = 3'd2;
  localparam logic [2:0] ST_BAD_VER  = 3'd3;
  localparam logic [2:0] ST_BAD_CRC  = 3'd4;
  localparam logic [2:0] ST_BAD_BODY = 3'd5;

  localparam int QUEUE_DEPTH = 2;

  // captured record, handed from front to back
  typedef struct packed {
    logic [4:0]      count;
    logic            crc_ok;
    logic [11:0][7:0] hdr;
    logic [11:0][7:0] body;
  } rec_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  record_length;
    logic [15:0] capabilities;
    logic [3:0]  feature_flags;
    logic [1:0]  spk_path;
    logic        gov_mode;
    logic [1:0]  perf_level;
    logic [8:0]  cpu_mhz;
    logic [9:0]  haptics_gain;
    logic [5:0]  idle_timeout;
    logic        suspend_poweroff;
  } res_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/crv_front.sv @@
// ----------------------------------------------------------------------------
// crv_front - byte capture and running crc
// Counts bytes, updates the crc with the byte leaving the trailer window,
// captures header and body bytes and emits a record on the last byte.
// ----------------------------------------------------------------------------
module crv_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output logic              rec_valid,
  output crv_pkg::rec_t     rec
);

  logic [4:0]       cnt_r;
  logic [31:0]      crc_r, crc_nxt;
  logic [31:0]      win_r, win_nxt;
  logic [11:0][7:0] hdr_r, hdr_nxt;
  logic [11:0][7:0] body_r, body_nxt;

  always_comb begin
    hdr_nxt  = hdr_r;
    body_nxt = body_r;
    if (cnt_r < 5'd12) begin
      hdr_nxt[cnt_r[3:0]] = in_byte;
    end else if (cnt_r < 5'd24) begin
      body_nxt[4'(cnt_r - 5'd12)] = in_byte;
    end
    crc_nxt = (cnt_r >= 5'd4) ? crv_pkg::crc_byte(crc_r, win_r[7:0]) : crc_r;
    win_nxt = {in_byte, win_r[31:8]};
  end

  assign rec_valid     = in_valid && in_last;
  assign rec.count     = (cnt_r == 5'd31) ? cnt_r : cnt_r + 5'd1;
  assign rec.crc_ok    = (~crc_nxt) == win_nxt;
  assign rec.hdr       = hdr_nxt;
  assign rec.body      = body_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || rec_valid) begin
      cnt_r  <= '0;
      crc_r  <= '1;
      win_r  <= '0;
      hdr_r  <= '0;
      body_r <= '0;
    end else if (in_valid) begin
      cnt_r  <= rec.count;
      crc_r  <= crc_nxt;
      win_r  <= win_nxt;
      hdr_r  <= hdr_nxt;
      body_r <= body_nxt;
    end
  end

endmodule

@@ rtl/crv_queue.sv @@
// ----------------------------------------------------------------------------
// crv_queue - short record queue
// Two-entry fifo between the capture front and the checking back.
// ----------------------------------------------------------------------------
module crv_queue #(
  parameter int DEPTH = crv_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  crv_pkg::rec_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output logic          empty,
  output crv_pkg::rec_t rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  crv_pkg::rec_t  mem_r [DEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;

  assign full    = cnt_r == (AW+1)'(DEPTH);
  assign empty   = cnt_r == '0;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en && !full) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (rd_en && !empty) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && !empty);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= (AW+1)'(DEPTH))
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n) empty |-> !full)
    else $error("queue both empty and full");
  assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !full && !(rd_en && !empty)) |=> !empty)
    else $error("queue empty after write");

endmodule

@@ rtl/crv_back.sv @@
// ----------------------------------------------------------------------------
// crv_back - record checks and field decode
// Applies the check chain to a captured record and holds one result in an
// output register.
// ----------------------------------------------------------------------------
module crv_back #(
  parameter logic [7:0] NEW_SCHEMA_VERSION = 8'(crv_pkg::NEW_SCHEMA_VERSION_DEF),
  parameter logic [7:0] NEW_RECORD_VERSION = 8'(crv_pkg::NEW_RECORD_VERSION_DEF)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rec_valid,
  input  crv_pkg::rec_t rec,
  output logic          rec_take,
  output logic          res_valid,
  output crv_pkg::res_t res,
  input  logic          res_pop
);

  logic          val_r;
  crv_pkg::res_t res_r, res_nxt;
  logic [7:0]    ver, osize, iver, isize, route, gov, prof, idle;
  logic [15:0]   mhz, gain;
  logic [4:0]    expect_len;
  logic          pair_ok, inner_ok, range_ok;
  logic [2:0]    st;

  always_comb begin
    ver   = rec.hdr[4];
    osize = rec.hdr[5];
    iver  = rec.hdr[10];
    isize = rec.hdr[11];
    route = rec.body[3];
    gov   = rec.body[4];
    prof  = rec.body[5];
    mhz   = {rec.body[7], rec.body[6]};
    gain  = {rec.body[9], rec.body[8]};
    idle  = (iver == NEW_SCHEMA_VERSION) ? rec.body[10] : 8'd0;
    pair_ok = 1'b1;
    expect_len = crv_pkg::OLD_RECORD_SIZE;
    if (ver == crv_pkg::OLD_VERSION && osize == crv_pkg::OLD_BODY_SIZE) begin
      expect_len = crv_pkg::OLD_RECORD_SIZE;
    end else if (ver == NEW_RECORD_VERSION && osize == crv_pkg::NEW_BODY_SIZE) begin
      expect_len = crv_pkg::NEW_RECORD_SIZE;
    end else begin
      pair_ok = 1'b0;
    end
    inner_ok = ({rec.hdr[9], rec.hdr[8], rec.hdr[7], rec.hdr[6]} == crv_pkg::INNER_MAGIC)
      && ((iver == crv_pkg::OLD_VERSION && isize == crv_pkg::OLD_BODY_SIZE)
       || (iver == NEW_SCHEMA_VERSION && isize == crv_pkg::NEW_BODY_SIZE))
      && (osize >= isize);
    range_ok = (route <= 8'd2) && (gov <= 8'd1) && (prof <= 8'd3)
      && (mhz >= crv_pkg::MHZ_MIN) && (mhz <= crv_pkg::MHZ_MAX)
      && (gain >= crv_pkg::GAIN_MIN) && (gain <= crv_pkg::GAIN_MAX)
      && (idle <= crv_pkg::IDLE_MAX);

    if (rec.count != crv_pkg::NEW_RECORD_SIZE && rec.count != crv_pkg::OLD_RECORD_SIZE) begin
      st = crv_pkg::ST_BAD_LEN;
    end else if ({rec.hdr[3], rec.hdr[2], rec.hdr[1], rec.hdr[0]} != crv_pkg::OUTER_MAGIC) begin
      st = crv_pkg::ST_BAD_MAG;
    end else if (!pair_ok) begin
      st = crv_pkg::ST_BAD_VER;
    end else if (rec.count != expect_len) begin
      st = crv_pkg::ST_BAD_LEN;
    end else if (!rec.crc_ok) begin
      st = crv_pkg::ST_BAD_CRC;
    end else if (!inner_ok || !range_ok) begin
      st = crv_pkg::ST_BAD_BODY;
    end else begin
      st = crv_pkg::ST_OK;
    end

    res_nxt = '0;
    res_nxt.status = st;
    if (st == crv_pkg::ST_OK) begin
      res_nxt.record_length    = rec.count;
      res_nxt.capabilities     = {rec.body[1], rec.body[0]};
      res_nxt.feature_flags    = rec.body[2][3:0];
      res_nxt.spk_path         = route[1:0];
      res_nxt.gov_mode         = gov[0];
      res_nxt.perf_level       = prof[1:0];
      res_nxt.cpu_mhz          = mhz[8:0];
      res_nxt.haptics_gain     = gain[9:0];
      res_nxt.idle_timeout     = idle[5:0];
      res_nxt.suspend_poweroff = (iver == NEW_SCHEMA_VERSION) ? rec.body[11][0] : 1'b0;
    end
  end

  // output register frees whenever it is empty or being popped
  assign rec_take  = rec_valid && (!val_r || res_pop);
  assign res_valid = val_r;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (rec_take) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= 1'b0;
    end else if (rec_take) begin
      val_r <= 1'b1;
    end else if (res_pop) begin
      val_r <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (val_r && res_r.status != crv_pkg::ST_OK) |-> res_r.record_length == '0)
    else $error("error result carries fields");
  assert property (@(posedge clk) disable iff (!rst_n)
    (val_r && !res_pop) |=> (val_r && $stable(res_r)))
    else $error("held result changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    (val_r && res_r.status == crv_pkg::ST_OK) |->
    (res_r.record_length == crv_pkg::OLD_RECORD_SIZE
     || res_r.record_length == crv_pkg::NEW_RECORD_SIZE))
    else $error("ok result with bad length");

endmodule

@@ rtl/crv_record_top.sv @@
// ----------------------------------------------------------------------------
// crc_record_validate_decode - settings record validator and decoder
// Byte-wide front with crc, record queue and checking back with output reg.
// ----------------------------------------------------------------------------
// a last-byte record goes to a queue entry, then into the output register
// throughput: one byte per cycle unless full, back-to-back records included
// the two-entry record queue and output register absorb pop stalls; full
// rises once both queue entries hold records behind a held result
// synchronous active-low reset clears counters, crc, queue and output valid
module crc_record_validate_decode #(
  parameter int NEW_SCHEMA_VERSION = crv_pkg::NEW_SCHEMA_VERSION_DEF,
  parameter int NEW_RECORD_VERSION = crv_pkg::NEW_RECORD_VERSION_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_status,
  output logic [4:0]  out_record_length,
  output logic [15:0] out_capabilities,
  output logic [3:0]  out_feature_flags,
  output logic [1:0]  out_spk_path,
  output logic        out_gov_mode,
  output logic [1:0]  out_perf_level,
  output logic [8:0]  out_cpu_mhz,
  output logic [9:0]  out_haptics_gain,
  output logic [5:0]  out_idle_timeout,
  output logic        out_suspend_poweroff
);

  logic          f_valid, q_full, q_empty, take, r_valid;
  crv_pkg::rec_t f_rec, q_rec;
  crv_pkg::res_t r;

  assign full = q_full;

  crv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (push && !q_full),
    .in_byte   (in_data_byte),
    .in_last   (in_last_byte),
    .rec_valid (f_valid),
    .rec       (f_rec)
  );

  crv_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (f_valid),
    .wr_data (f_rec),
    .full    (q_full),
    .rd_en   (take),
    .empty   (q_empty),
    .rd_data (q_rec)
  );

  crv_back #(
    .NEW_SCHEMA_VERSION (8'(NEW_SCHEMA_VERSION)),
    .NEW_RECORD_VERSION (8'(NEW_RECORD_VERSION))
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (!q_empty),
    .rec       (q_rec),
    .rec_take  (take),
    .res_valid (r_valid),
    .res       (r),
    .res_pop   (pop)
  );

  assign empty                = !r_valid;
  assign out_status           = r.status;
  assign out_record_length    = r.record_length;
  assign out_capabilities     = r.capabilities;
  assign out_feature_flags    = r.feature_flags;
  assign out_spk_path         = r.spk_path;
  assign out_gov_mode         = r.gov_mode;
  assign out_perf_level       = r.perf_level;
  assign out_cpu_mhz          = r.cpu_mhz;
  assign out_haptics_gain     = r.haptics_gain;
  assign out_idle_timeout     = r.idle_timeout;
  assign out_suspend_poweroff = r.suspend_poweroff;

endmodule
